>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the formatter RTL.
// Files that check their own logic include this header; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge outside reset.
`define AST_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define AST_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// Antecedent implies consequent in the next cycle.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AST_ALWAYS(lbl, clk, rst_n, cond, msg)
`define AST_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hw/rtl/itpda_pkg.sv
// Types and constants for the padded decimal ASCII formatter.
// No dependencies; every RTL module and interface imports this package.
package itpda_pkg;

	localparam int VALUE_W    = 32;
	localparam int FWIDTH_W   = 5;
	localparam int CHAR_W     = 8;
	localparam int NUM_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
	localparam int NDIG_W     = 4;
	localparam int CONV_CNT_W = 5;
	localparam int MAX_OUT    = 31;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W     = 1;
	localparam int QCNT_W     = 2;

	localparam logic [CONV_CNT_W-1:0] CONV_LAST = CONV_CNT_W'(VALUE_W - 1);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

	// One converted number waiting for serialization.
	typedef struct packed {
		bcd_t                bcd;
		logic [NDIG_W-1:0]   nd;
		logic                neg;
		logic [FWIDTH_W-1:0] npad;
		logic                zpad;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SIGN,
		B_PAD,
		B_DIG
	} back_state_t;

endpackage

>>> hw/rtl/itpda_in_if.sv
// Input channel of the formatter: valid/ready handshake plus one number request.
// Depends on itpda_pkg for field widths.
interface itpda_in_if;
	import itpda_pkg::*;

	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  value_bits;
	logic                is_signed;
	logic [FWIDTH_W-1:0] field_width;
	logic                zero_pad;

	modport source(output valid, value_bits, is_signed, field_width, zero_pad, input ready);
	modport sink(input valid, value_bits, is_signed, field_width, zero_pad, output ready);
endinterface

>>> hw/rtl/itpda_out_if.sv
// Output channel of the formatter: valid/ready handshake plus one character.
// Depends on itpda_pkg for field widths.
interface itpda_out_if;
	import itpda_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              last_char;

	modport source(output valid, out_char, last_char, input ready);
	modport sink(input valid, out_char, last_char, output ready);
endinterface

>>> hw/rtl/int_to_padded_decimal_ascii_core.sv
// Padded decimal ASCII formatter: takes one 32-bit number per transfer on item and sends
// its text, sign first, then pad characters, then digits, one character per transfer on
// chars, with last_char marking the final one. Field width counts the sign and is clamped
// to min(MAX_CHARS-1, 31); only padding is ever shortened. The converter accepts a number,
// runs 32 shift-and-add-3 steps of the binary-to-BCD loop and hands the job off; the
// serializer takes a load step, then sends one character per cycle while chars is not
// stalled. A two-entry queue lets the two overlap, so the converter can take a new number
// while the serializer is still sending the last one.
module int_to_padded_decimal_ascii_core #(
	parameter int MAX_CHARS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	itpda_in_if.sink     item,
	itpda_out_if.source  chars
);
	import itpda_pkg::*;

	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	itpda_front #(
		.MAX_CHARS(MAX_CHARS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.job       (push_job)
	);

	itpda_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job  (push_job),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job)
	);

	itpda_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_job  (pop_job),
		.chars    (chars)
	);

endmodule

>>> hw/rtl/itpda_front.sv
// Front end: accepts a number, takes its magnitude, converts it to BCD by shift-and-add-3
// and works out digit count and padding. Depends on itpda_pkg, itpda_in_if, assert_macros.svh.
`include "assert_macros.svh"
module itpda_front #(
	parameter int MAX_CHARS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	itpda_in_if.sink         item,
	output logic             push_valid,
	input  logic             push_ready,
	output itpda_pkg::job_t  job
);
	import itpda_pkg::*;

	localparam int LIMIT = (MAX_CHARS - 1 > MAX_OUT) ? MAX_OUT : MAX_CHARS - 1;
	localparam logic [FWIDTH_W-1:0] LIMIT_W = FWIDTH_W'(LIMIT);

	front_state_t            state_q, state_d;
	logic [CONV_CNT_W-1:0]   cnt_q;
	logic [VALUE_W-1:0]      mag_q;
	bcd_t                    bcd_q;
	bcd_t                    bcd_adj;
	logic [BCD_W-1:0]        bcd_vec;
	logic                    neg_q;
	logic [FWIDTH_W-1:0]     wid_q;
	logic                    zpad_q;
	logic                    take;
	logic                    in_neg;
	logic [NDIG_W-1:0]       nd;
	logic [NDIG_W-1:0]       used;
	logic [FWIDTH_W-1:0]     npad;
	logic [FWIDTH_W:0]       total_len;

	assign take   = item.valid && item.ready;
	assign in_neg = item.is_signed && item.value_bits[VALUE_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_CONV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mag_q  <= in_neg ? (VALUE_W'(0) - item.value_bits) : item.value_bits;
			bcd_q  <= '0;
			neg_q  <= in_neg;
			wid_q  <= (item.field_width > LIMIT_W) ? LIMIT_W : item.field_width;
			zpad_q <= item.zero_pad;
		end else if (state_q == F_CONV) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_vec[BCD_W-2:0], mag_q[VALUE_W-1]};
		end
	end

	// Add 3 to every digit of 5 or more before the shift.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= DIGIT_W'(5)) ? bcd_q[i] + DIGIT_W'(3) : bcd_q[i];
		end
		bcd_vec = bcd_adj;
	end

	// Leading-digit search: zero still prints one digit.
	always_comb begin
		nd = NDIG_W'(1);
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i] != '0) begin
				nd = NDIG_W'(i + 1);
			end
		end
	end

	assign used      = nd + NDIG_W'(neg_q);
	assign npad      = (wid_q > FWIDTH_W'(used)) ? wid_q - FWIDTH_W'(used) : '0;
	assign total_len = (FWIDTH_W + 1)'(used) + (FWIDTH_W + 1)'(npad);

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		push_valid = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = F_CONV;
				end
			end
			F_CONV: begin
				if (cnt_q == CONV_LAST) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	assign job.bcd  = bcd_q;
	assign job.nd   = nd;
	assign job.neg  = neg_q;
	assign job.npad = npad;
	assign job.zpad = zpad_q;

	`AST_IMPL(a_nd_range, clk, arst_n, push_valid, (nd >= NDIG_W'(1)) && (nd <= NDIG_W'(NUM_DIGITS)), "digit count out of range")
	`AST_IMPL(a_len_limit, clk, arst_n, push_valid && (npad != '0), total_len <= (FWIDTH_W + 1)'(LIMIT), "padded length over limit")

endmodule

>>> hw/rtl/itpda_queue.sv
// Short job queue between converter and serializer so each side stalls on its own.
// Depends on itpda_pkg.
module itpda_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  itpda_pkg::job_t  push_job,
	output logic             pop_valid,
	input  logic             pop_ready,
	output itpda_pkg::job_t  pop_job
);
	import itpda_pkg::*;

	job_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_job    = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

>>> hw/rtl/itpda_back.sv
// Back end: serializes one converted number into sign, pad and digit characters
// through an output register. Depends on itpda_pkg, itpda_out_if, assert_macros.svh.
`include "assert_macros.svh"
module itpda_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  itpda_pkg::job_t  pop_job,
	itpda_out_if.source      chars
);
	import itpda_pkg::*;

	back_state_t         state_q, state_d;
	job_t                job_q;
	logic [FWIDTH_W-1:0] pad_cnt_q;
	logic [NDIG_W-1:0]   dig_idx_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                out_last_q;
	logic                adv;
	logic                load;
	logic                emit;
	logic [CHAR_W-1:0]   char_nxt;
	logic                last_nxt;
	logic [CHAR_W-1:0]   pad_char;
	logic [CHAR_W-1:0]   dig_char;

	// Output register is free when empty or being drained this cycle.
	assign adv      = !out_valid_q || chars.ready;
	assign pad_char = job_q.zpad ? CHAR_ZERO : CHAR_SPACE;
	assign dig_char = CHAR_ZERO + CHAR_W'(job_q.bcd[dig_idx_q]);

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		load      = 1'b0;
		emit      = 1'b0;
		char_nxt  = CHAR_ZERO;
		last_nxt  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					load = 1'b1;
					if (pop_job.neg) begin
						state_d = B_SIGN;
					end else if (pop_job.npad != '0) begin
						state_d = B_PAD;
					end else begin
						state_d = B_DIG;
					end
				end
			end
			B_SIGN: begin
				if (adv) begin
					emit     = 1'b1;
					char_nxt = CHAR_MINUS;
					state_d  = (job_q.npad != '0) ? B_PAD : B_DIG;
				end
			end
			B_PAD: begin
				if (adv) begin
					emit     = 1'b1;
					char_nxt = pad_char;
					if (pad_cnt_q == FWIDTH_W'(1)) begin
						state_d = B_DIG;
					end
				end
			end
			B_DIG: begin
				if (adv) begin
					emit     = 1'b1;
					char_nxt = dig_char;
					last_nxt = (dig_idx_q == '0);
					if (dig_idx_q == '0) begin
						state_d = B_IDLE;
					end
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			pad_cnt_q   <= '0;
			dig_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				pad_cnt_q <= pop_job.npad;
				dig_idx_q <= pop_job.nd - 1'b1;
			end else if (emit && state_q == B_PAD) begin
				pad_cnt_q <= pad_cnt_q - 1'b1;
			end else if (emit && state_q == B_DIG) begin
				dig_idx_q <= dig_idx_q - 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (chars.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= pop_job;
		end
		if (emit) begin
			out_char_q <= char_nxt;
			out_last_q <= last_nxt;
		end
	end

	assign chars.valid     = out_valid_q;
	assign chars.out_char  = out_char_q;
	assign chars.last_char = out_last_q;

	`AST_IMPL(a_dig_idx, clk, arst_n, state_q == B_DIG, dig_idx_q < job_q.nd, "digit index past digit count")
	`AST_NEXT(a_last_ends, clk, arst_n, emit && last_nxt, state_q == B_IDLE && out_valid_q && out_last_q, "last character did not end the number")

endmodule
